>>> rtl/q24_8_fixed_point_alu_macros.svh
// assertion macros used by the q24.8 alu top level
`ifndef Q24_8_FIXED_POINT_ALU_MACROS_SVH
`define Q24_8_FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication, disabled during reset
`define Q24_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define Q24_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/q24alu_pkg.sv
// shared types, constants and saturation helper for the q24.8 alu
`default_nettype none

package q24alu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 4;

  // numerator of the divider: |a| shifted up by the fraction bits
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;

  localparam int IN_FIELDS_W  = FUNC_W + 2 * DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [63:0] POS_LIM    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIM    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_FROM_INT = 4'd14,
    FN_TO_INT   = 4'd15
  } func_t;

  // item context that rides along the pipeline
  typedef struct packed {
    logic              is_mul;
    logic              is_div;
    logic              neg;
    logic              div0;
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic              err;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              err;
  } sat_t;

  // apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
    sat_t s;
    if (neg) begin
      if (m > NEG_LIM) begin
        s.value = Q_MIN;
        s.err   = 1'b1;
      end else begin
        s.value = DATA_W'(-m[DATA_W-1:0]);
        s.err   = 1'b0;
      end
    end else begin
      if (m > POS_LIM) begin
        s.value = Q_MAX;
        s.err   = 1'b1;
      end else begin
        s.value = m[DATA_W-1:0];
        s.err   = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/q24alu_front.sv
// input register and decode stage: simple ops, magnitudes, sign of mul/div
`default_nettype none

module q24alu_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             adv,
  input  wire logic                             in_valid,
  input  wire logic [q24alu_pkg::FUNC_W-1:0]    func,
  input  wire logic [q24alu_pkg::DATA_W-1:0]    operand_a,
  input  wire logic [q24alu_pkg::DATA_W-1:0]    operand_b,
  output logic                                  out_valid,
  output q24alu_pkg::ctl_t                      out_ctl,
  output logic [q24alu_pkg::DATA_W-1:0]         mag_a,
  output logic [q24alu_pkg::DATA_W-1:0]         mag_b
);
  import q24alu_pkg::*;

  localparam logic signed [DATA_W-1:0] FI_HI = Q_MAX >>> FRAC_BITS;
  localparam logic signed [DATA_W-1:0] FI_LO = Q_MIN >>> FRAC_BITS;

  logic                     v1;
  func_t                    fn1;
  logic signed [DATA_W-1:0] a1;
  logic signed [DATA_W-1:0] b1;

  logic signed [DATA_W:0] sum;
  logic signed [DATA_W:0] dif;
  logic signed [DATA_W:0] incr;
  logic signed [DATA_W:0] decr;
  logic                   lt;
  logic                   eq;
  ctl_t                   ctl_next;

  // 33-bit result clamped to 32 bits
  function automatic sat_t sat33(input logic [DATA_W:0] v);
    sat_t s;
    if (v[DATA_W] != v[DATA_W-1]) begin
      s.value = v[DATA_W] ? Q_MIN : Q_MAX;
      s.err   = 1'b1;
    end else begin
      s.value = v[DATA_W-1:0];
      s.err   = 1'b0;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn1 <= func_t'(func);
      a1  <= operand_a;
      b1  <= operand_b;
    end
  end

  assign sum  = {a1[DATA_W-1], a1} + {b1[DATA_W-1], b1};
  assign dif  = {a1[DATA_W-1], a1} - {b1[DATA_W-1], b1};
  assign incr = {a1[DATA_W-1], a1} + (DATA_W+1)'(1);
  assign decr = {a1[DATA_W-1], a1} - (DATA_W+1)'(1);
  assign lt   = a1 < b1;
  assign eq   = a1 == b1;

  always_comb begin
    ctl_next        = '0;
    ctl_next.is_mul = (fn1 == FN_MUL);
    ctl_next.is_div = (fn1 == FN_DIV);
    ctl_next.neg    = a1[DATA_W-1] ^ b1[DATA_W-1];
    ctl_next.div0   = (b1 == '0);
    case (fn1)
      FN_ADD: {ctl_next.res, ctl_next.err} = sat33(sum);
      FN_SUB: {ctl_next.res, ctl_next.err} = sat33(dif);
      FN_INC: {ctl_next.res, ctl_next.err} = sat33(incr);
      FN_DEC: {ctl_next.res, ctl_next.err} = sat33(decr);
      FN_GT:  ctl_next.cmp = !lt && !eq;
      FN_LT:  ctl_next.cmp = lt;
      FN_GE:  ctl_next.cmp = !lt;
      FN_LE:  ctl_next.cmp = lt || eq;
      FN_EQ:  ctl_next.cmp = eq;
      FN_NE:  ctl_next.cmp = !eq;
      FN_MIN: ctl_next.res = lt ? a1 : b1;
      FN_MAX: ctl_next.res = (!lt && !eq) ? a1 : b1;
      FN_FROM_INT: begin
        if (a1 > FI_HI) begin
          ctl_next.res = Q_MAX;
          ctl_next.err = 1'b1;
        end else if (a1 < FI_LO) begin
          ctl_next.res = Q_MIN;
          ctl_next.err = 1'b1;
        end else begin
          ctl_next.res = a1 <<< FRAC_BITS;
        end
      end
      FN_TO_INT: ctl_next.res = a1 >>> FRAC_BITS;
      default: begin
        // mul and div are resolved further down the pipe
        ctl_next.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl <= ctl_next;
      mag_a   <= a1[DATA_W-1] ? DATA_W'(-a1) : DATA_W'(a1);
      mag_b   <= b1[DATA_W-1] ? DATA_W'(-b1) : DATA_W'(b1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/q24alu_mul.sv
// two-stage magnitude multiplier with round half away from zero and saturation
`default_nettype none

module q24alu_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire q24alu_pkg::ctl_t              in_ctl,
  input  wire logic [q24alu_pkg::DATA_W-1:0] in_mag_a,
  input  wire logic [q24alu_pkg::DATA_W-1:0] in_mag_b,
  output logic                               out_valid,
  output q24alu_pkg::ctl_t                   out_ctl,
  output logic [q24alu_pkg::DATA_W-1:0]      mag_a,
  output logic [q24alu_pkg::DATA_W-1:0]      mag_b
);
  import q24alu_pkg::*;

  logic              v1;
  ctl_t              ctl1;
  logic [DATA_W-1:0] ma1;
  logic [DATA_W-1:0] mb1;
  logic [63:0]       prod;
  logic [63:0]       rounded;
  sat_t              mul_sat;
  ctl_t              ctl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 1: 32x32 product
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= 64'(in_mag_a) * 64'(in_mag_b);
      ctl1 <= in_ctl;
      ma1  <= in_mag_a;
      mb1  <= in_mag_b;
    end
  end

  // stage 2: round, sign, clamp
  assign rounded = (prod + ROUND_HALF) >> FRAC_BITS;
  assign mul_sat = sat_mag(rounded, ctl1.neg);

  always_comb begin
    ctl_next = ctl1;
    if (ctl1.is_mul) begin
      ctl_next.res = mul_sat.value;
      ctl_next.err = mul_sat.err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl <= ctl_next;
      mag_a   <= ma1;
      mag_b   <= mb1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/q24alu_div.sv
// pipelined restoring divider, four quotient bits per stage
`default_nettype none

module q24alu_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire q24alu_pkg::ctl_t              in_ctl,
  input  wire logic [q24alu_pkg::DATA_W-1:0] mag_a,
  input  wire logic [q24alu_pkg::DATA_W-1:0] mag_b,
  output logic                               out_valid,
  output q24alu_pkg::ctl_t                   out_ctl,
  output logic [q24alu_pkg::NUM_W-1:0]       quotient,
  output logic [q24alu_pkg::DATA_W-1:0]      remainder,
  output logic [q24alu_pkg::DATA_W-1:0]      divisor
);
  import q24alu_pkg::*;

  logic              vld_q [DIV_STAGES];
  ctl_t              ctl_q [DIV_STAGES];
  logic [NUM_W-1:0]  nq_q  [DIV_STAGES];
  logic [DATA_W-1:0] rem_q [DIV_STAGES];
  logic [DATA_W-1:0] dvs_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic              vld_in;
    ctl_t              ctl_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W-1:0] dvs_in;
    logic [NUM_W-1:0]  nq_d;
    logic [DATA_W-1:0] rem_d;
    logic [DATA_W:0]   trial;

    if (g == 0) begin : g_src
      assign vld_in = in_valid;
      assign ctl_in = in_ctl;
      assign nq_in  = {mag_a, {FRAC_BITS{1'b0}}};
      assign rem_in = '0;
      assign dvs_in = mag_b;
    end else begin : g_src
      assign vld_in = vld_q[g-1];
      assign ctl_in = ctl_q[g-1];
      assign nq_in  = nq_q[g-1];
      assign rem_in = rem_q[g-1];
      assign dvs_in = dvs_q[g-1];
    end

    // numerator shifts out at the top, quotient bits shift in at the bottom
    always_comb begin
      nq_d  = nq_in;
      rem_d = rem_in;
      trial = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (g * DIV_STEP + j < NUM_W) begin
          trial = {rem_d, nq_d[NUM_W-1]};
          if (trial >= {1'b0, dvs_in}) begin
            rem_d = DATA_W'(trial - {1'b0, dvs_in});
            nq_d  = {nq_d[NUM_W-2:0], 1'b1};
          end else begin
            rem_d = trial[DATA_W-1:0];
            nq_d  = {nq_d[NUM_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (adv) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_q[g] <= ctl_in;
        nq_q[g]  <= nq_d;
        rem_q[g] <= rem_d;
        dvs_q[g] <= dvs_in;
      end
    end
  end

  assign out_valid = vld_q[DIV_STAGES-1];
  assign out_ctl   = ctl_q[DIV_STAGES-1];
  assign quotient  = nq_q[DIV_STAGES-1];
  assign remainder = rem_q[DIV_STAGES-1];
  assign divisor   = dvs_q[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/q24alu_back.sv
// divide rounding and saturation, final select and output register
`default_nettype none

module q24alu_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire q24alu_pkg::ctl_t              in_ctl,
  input  wire logic [q24alu_pkg::NUM_W-1:0]  quotient,
  input  wire logic [q24alu_pkg::DATA_W-1:0] remainder,
  input  wire logic [q24alu_pkg::DATA_W-1:0] divisor,
  output logic                               out_valid,
  output logic [q24alu_pkg::DATA_W-1:0]      result_value,
  output logic                               compare_true,
  output logic                               error_flag
);
  import q24alu_pkg::*;

  logic        round_up;
  logic [63:0] q_mag;
  sat_t        div_sat;
  sat_t        sel;

  // round half away from zero: bump when twice the remainder reaches the divisor
  assign round_up = {remainder, 1'b0} >= {1'b0, divisor};
  assign q_mag    = 64'(quotient) + 64'(round_up);
  assign div_sat  = sat_mag(q_mag, in_ctl.neg);

  always_comb begin
    if (!in_ctl.is_div) begin
      sel.value = in_ctl.res;
      sel.err   = in_ctl.err;
    end else if (in_ctl.div0) begin
      sel.value = '0;
      sel.err   = 1'b1;
    end else begin
      sel = div_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= sel.value;
      compare_true <= in_ctl.cmp;
      error_flag   <= sel.err;
    end
  end

endmodule

`default_nettype wire

>>> rtl/q24_8_fixed_point_alu.sv
// q24.8 alu: one operation in and one result out per cycle while the result side does not stall
// a result passes the front, multiplier, divider and back registers before it shows on m_tvalid
// throughput is one transfer per cycle when not stalled; the divider, 4 quotient bits per stage, sets the depth
// a stall on the result side freezes the whole pipe together, nothing dropped or repeated
// synchronous reset clears every valid bit; the data registers keep their contents
`default_nettype none
`include "q24_8_fixed_point_alu_macros.svh"

module q24_8_fixed_point_alu (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // func [3:0], operand_a [35:4], operand_b [67:36], zero pad above
  input  wire logic [q24alu_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // result_value [31:0], compare_true [32], error_flag [33], zero pad above
  output logic [q24alu_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import q24alu_pkg::*;

  // every stage moves when the output register is free or being drained
  logic adv;

  logic              fr_valid;
  ctl_t              fr_ctl;
  logic [DATA_W-1:0] fr_mag_a;
  logic [DATA_W-1:0] fr_mag_b;

  logic              mu_valid;
  ctl_t              mu_ctl;
  logic [DATA_W-1:0] mu_mag_a;
  logic [DATA_W-1:0] mu_mag_b;

  logic              dv_valid;
  ctl_t              dv_ctl;
  logic [NUM_W-1:0]  dv_quo;
  logic [DATA_W-1:0] dv_rem;
  logic [DATA_W-1:0] dv_dvs;

  logic [DATA_W-1:0] result_value;
  logic              compare_true;
  logic              error_flag;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input register plus decode of simple operations
  q24alu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .func      (s_tdata[FUNC_W-1:0]),
    .operand_a (s_tdata[FUNC_W+DATA_W-1:FUNC_W]),
    .operand_b (s_tdata[FUNC_W+2*DATA_W-1:FUNC_W+DATA_W]),
    .out_valid (fr_valid),
    .out_ctl   (fr_ctl),
    .mag_a     (fr_mag_a),
    .mag_b     (fr_mag_b)
  );

  // multiply resolves here; magnitudes pass on to the divider
  q24alu_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_ctl    (fr_ctl),
    .in_mag_a  (fr_mag_a),
    .in_mag_b  (fr_mag_b),
    .out_valid (mu_valid),
    .out_ctl   (mu_ctl),
    .mag_a     (mu_mag_a),
    .mag_b     (mu_mag_b)
  );

  // every item walks the divider so all operations share one latency
  q24alu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (mu_valid),
    .in_ctl    (mu_ctl),
    .mag_a     (mu_mag_a),
    .mag_b     (mu_mag_b),
    .out_valid (dv_valid),
    .out_ctl   (dv_ctl),
    .quotient  (dv_quo),
    .remainder (dv_rem),
    .divisor   (dv_dvs)
  );

  // divide rounding, final select, output register
  q24alu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (dv_valid),
    .in_ctl       (dv_ctl),
    .quotient     (dv_quo),
    .remainder    (dv_rem),
    .divisor      (dv_dvs),
    .out_valid    (m_tvalid),
    .result_value (result_value),
    .compare_true (compare_true),
    .error_flag   (error_flag)
  );

  assign m_tdata = OUT_TDATA_W'({error_flag, compare_true, result_value});

  // a true comparison carries a zero value and no error
  `Q24_ASSERT_SAME(a_cmp_clean, m_tvalid && m_tdata[DATA_W], m_tdata[DATA_W-1:0] == '0 && !m_tdata[DATA_W+1], "comparison result not clean")

  // divide by zero reaching the back stage comes out as zero with the error flag
  `Q24_ASSERT_NEXT(a_div0_out, adv && dv_valid && dv_ctl.is_div && dv_ctl.div0, m_tvalid && m_tdata[DATA_W+1] && m_tdata[DATA_W-1:0] == '0, "divide by zero result wrong")

  // a held result freezes the divider tail
  `Q24_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, $stable(dv_valid) && $stable(dv_quo) && $stable(dv_ctl), "pipe moved during stall")

endmodule

`default_nettype wire
